>>> hw/rtl/twcm_pkg.sv
// ---------------------------------------------------------------------------
// twcm_pkg: shared types and constants of the textured wall column mapper
// Holds the screen size, the field codes, the FSM state type and the small
// helper functions used by the mapper and its divider.
// ---------------------------------------------------------------------------
`default_nettype none

package twcm_pkg;

   localparam int SCREEN_ROWS = 480;
   localparam int HALF_ROWS   = SCREEN_ROWS / 2;

   localparam int DIV_W      = 27;   // dividend and quotient width
   localparam int DIVISOR_W  = 16;
   localparam int DIV_CNT_W  = $clog2(DIV_W);

   localparam int SUM_W  = 18;       // signed start row offset
   localparam int STEP_W = 27;       // texture step, Q11.16, never above 2^26
   localparam int PROD_W = SUM_W + STEP_W + 1;

   localparam logic [10:0] TEX_SIZE_MAX = 11'd1024;

   localparam logic ACTION_START = 1'b0;
   localparam logic ACTION_ROW   = 1'b1;

   localparam logic CSR_CEILING = 1'b0;
   localparam logic CSR_FLOOR   = 1'b1;

   typedef enum logic [1:0] {
      REGION_NONE    = 2'd0,
      REGION_CEILING = 2'd1,
      REGION_WALL    = 2'd2,
      REGION_FLOOR   = 2'd3
   } region_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COL_DIV,
      ST_STEP_GO,
      ST_STEP_DIV,
      ST_MUL,
      ST_SAT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Texture sizes of zero count as one, sizes above 1024 count as 1024.
   function automatic logic [10:0] clamp_size(input logic [10:0] size);
      logic [10:0] result;
      if (size == 11'd0) begin
         result = 11'd1;
      end else if (size > TEX_SIZE_MAX) begin
         result = TEX_SIZE_MAX;
      end else begin
         result = size;
      end
      return result;
   endfunction

   // Clamp the texture column to the width, then mirror it when required.
   function automatic logic [9:0] finish_texel_x(input logic [DIV_W-1:0] tx,
                                                 input logic [10:0] width,
                                                 input logic mirror);
      logic [10:0] col;
      if (tx >= {{(DIV_W-11){1'b0}}, width}) begin
         col = width - 11'd1;
      end else begin
         col = tx[10:0];
      end
      if (mirror) begin
         col = width - col - 11'd1;
      end
      return col[9:0];
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/twcm_if.sv
// ---------------------------------------------------------------------------
// twcm_req_if / twcm_rsp_if: ready/valid channels of the column mapper
// The request channel carries start and row items, the response channel
// carries one row result per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface twcm_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [10:0] column;
   logic [11:0] wall_top;
   logic [11:0] wall_bottom;
   logic [15:0] wall_span;
   logic [15:0] hit_fraction;
   logic        vertical_side;
   logic        ray_x_positive;
   logic        ray_y_negative;
   logic [15:0] door_open;
   logic [10:0] texture_width;
   logic [10:0] texture_height;

   modport source (
      output valid, action, column, wall_top, wall_bottom, wall_span,
             hit_fraction, vertical_side, ray_x_positive, ray_y_negative,
             door_open, texture_width, texture_height,
      input  ready
   );
   modport sink (
      input  valid, action, column, wall_top, wall_bottom, wall_span,
             hit_fraction, vertical_side, ray_x_positive, ray_y_negative,
             door_open, texture_width, texture_height,
      output ready
   );
endinterface

interface twcm_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] out_column;
   logic [9:0]  out_row;
   logic [1:0]  region;
   logic [23:0] fill_rgb;
   logic [9:0]  texel_x;
   logic [9:0]  texel_y;
   logic        shade_half;
   logic        column_done;

   modport source (
      output valid, out_column, out_row, region, fill_rgb, texel_x, texel_y,
             shade_half, column_done,
      input  ready
   );
   modport sink (
      input  valid, out_column, out_row, region, fill_rgb, texel_x, texel_y,
             shade_half, column_done,
      output ready
   );
endinterface

`default_nettype wire

>>> hw/rtl/twcm_divider.sv
// ---------------------------------------------------------------------------
// twcm_divider: restoring unsigned divider, one quotient bit per cycle
// Shared by the texture column divide and the texture step divide.
// ---------------------------------------------------------------------------
`default_nettype none

module twcm_divider (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [twcm_pkg::DIV_W-1:0]       dividend,
   input  wire logic [twcm_pkg::DIVISOR_W-1:0]   divisor,
   output logic [twcm_pkg::DIV_W-1:0]            quotient,
   output twcm_pkg::div_status_type              status
);

   logic [twcm_pkg::DIV_W-1:0]     quot_ff;
   logic [twcm_pkg::DIVISOR_W-1:0] rem_ff;
   logic [twcm_pkg::DIVISOR_W-1:0] divisor_ff;
   logic [twcm_pkg::DIV_CNT_W-1:0] count_ff;
   logic                           busy_ff;
   logic                           done_ff;

   logic [twcm_pkg::DIVISOR_W:0]   rem_shift;
   logic [twcm_pkg::DIVISOR_W:0]   rem_trial;
   logic                           fits;
   logic                           last;

   // The remainder stays below the divisor, so the shifted value fits in one
   // extra bit.
   assign rem_shift = {rem_ff, quot_ff[twcm_pkg::DIV_W-1]};
   assign rem_trial = rem_shift - {1'b0, divisor_ff};
   assign fits      = rem_shift >= {1'b0, divisor_ff};
   assign last      = count_ff == twcm_pkg::DIV_CNT_W'(twcm_pkg::DIV_W - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= busy_ff && last;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 1'b1;
            if (last) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff    <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         quot_ff <= {quot_ff[twcm_pkg::DIV_W-2:0], fits};
         rem_ff  <= fits ? rem_trial[twcm_pkg::DIVISOR_W-1:0]
                         : rem_shift[twcm_pkg::DIVISOR_W-1:0];
      end
   end

   assign quotient    = quot_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

>>> hw/rtl/textured_wall_column_mapper.sv
// ---------------------------------------------------------------------------
// textured_wall_column_mapper: raycaster wall column to per-row texel mapper
// A start item loads one ray hit and prepares texture column, step and start
// position; each row item then yields the region, colour and texel of a row.
// ---------------------------------------------------------------------------
//  Channel  Dir  Handshake      Carries
//  req_bus  in   valid/ready    start item (ray hit) or row item
//  rsp_bus  out  valid/ready    one row result per row item of an open column
//  csr_*    in   write enable   ceiling_rgb (index 0), floor_rgb (index 1)
//
// A start item runs the door divide, when the hit lies on the closed part of a
// door, and the step divide on the shared one-bit-per-cycle divider (27 steps
// per divide), then the start-position multiply and saturate.
// Input is not taken while a start item is in work or a result is stalled.
// Reset is synchronous; afterwards no column is open and row items are
// consumed without a result until a start item arrives.
// ---------------------------------------------------------------------------
`default_nettype none

module textured_wall_column_mapper (
   input  wire logic        clock,
   input  wire logic        reset,
   twcm_req_if.sink         req_bus,
   twcm_rsp_if.source       rsp_bus,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [23:0] csr_write_data
);

   // Configuration registers
   logic [23:0] ceiling_ff;
   logic [23:0] floor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ceiling_ff <= '0;
         floor_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            twcm_pkg::CSR_CEILING: ceiling_ff <= csr_write_data;
            twcm_pkg::CSR_FLOOR:   floor_ff   <= csr_write_data;
            default:               ceiling_ff <= ceiling_ff;
         endcase
      end
   end

   // Sequencer
   twcm_pkg::state_type state_ff, state_in;

   logic req_ready;
   logic req_fire;
   logic start_fire;
   logic row_fire;
   logic div_start;
   logic store_div_col;
   logic store_step;
   logic load_prod;
   logic load_pos;

   twcm_pkg::div_status_type    div_status;
   logic [twcm_pkg::DIV_W-1:0]  div_quotient;
   logic [twcm_pkg::DIV_W-1:0]  div_dividend;
   logic [twcm_pkg::DIVISOR_W-1:0] div_divisor;

   // Column state
   logic [10:0] column_id_ff;
   logic [11:0] span_top_ff;
   logic [11:0] span_bottom_ff;
   logic        side_ff;
   logic [10:0] tex_rows_ff;
   logic [10:0] width_ff;
   logic [15:0] span_ff;
   logic        mirror_ff;
   logic        skipped_ff;
   logic [9:0]  texel_x_ff;
   logic [twcm_pkg::STEP_W-1:0]        step_ff;
   logic signed [twcm_pkg::PROD_W-1:0] prod_ff;
   logic [31:0] pos_ff, pos_in;
   logic [9:0]  row_ff, row_in;
   logic        open_ff, open_in;

   // Start item decode
   logic [10:0] width_c;
   logic [15:0] span_c;
   logic        door_c;
   logic        skipped_c;
   logic        mirror_c;
   logic [15:0] hit_off_c;
   logic [26:0] hit_prod_c;
   logic [9:0]  texel_x_c;

   assign req_ready  = (state_ff == twcm_pkg::ST_IDLE) && (!rsp_bus.valid || rsp_bus.ready);
   assign req_fire   = req_bus.valid && req_ready;
   assign start_fire = req_fire && (req_bus.action == twcm_pkg::ACTION_START);
   assign row_fire   = req_fire && (req_bus.action == twcm_pkg::ACTION_ROW);
   assign req_bus.ready = req_ready;

   assign width_c   = twcm_pkg::clamp_size(req_bus.texture_width);
   assign span_c    = (req_bus.wall_span == 16'd0) ? 16'd1 : req_bus.wall_span;
   assign door_c    = req_bus.door_open != 16'd0;
   assign skipped_c = door_c && (req_bus.hit_fraction < req_bus.door_open);
   assign mirror_c  = (!req_bus.vertical_side && req_bus.ray_x_positive) ||
                      (req_bus.vertical_side && req_bus.ray_y_negative);
   assign hit_off_c = door_c ? (req_bus.hit_fraction - req_bus.door_open)
                             : req_bus.hit_fraction;
   assign hit_prod_c = 27'(hit_off_c) * 27'(width_c);
   assign texel_x_c  = skipped_c ? 10'd0
                     : twcm_pkg::finish_texel_x(27'(hit_prod_c[26:16]), width_c, mirror_c);

   // The divider takes the door divide straight from the start transfer and
   // the step divide from the latched column state.
   always_comb begin
      if (state_ff == twcm_pkg::ST_IDLE) begin
         div_dividend = hit_prod_c;
         div_divisor  = 16'(~req_bus.door_open + 16'd1);
      end else begin
         div_dividend = {tex_rows_ff, 16'd0};
         div_divisor  = span_ff;
      end
   end

   twcm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .status   (div_status)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         twcm_pkg::ST_IDLE: begin
            if (start_fire) begin
               state_in = (door_c && !skipped_c) ? twcm_pkg::ST_COL_DIV
                                                 : twcm_pkg::ST_STEP_GO;
            end
         end
         twcm_pkg::ST_COL_DIV: begin
            if (div_status.done) begin
               state_in = twcm_pkg::ST_STEP_GO;
            end
         end
         twcm_pkg::ST_STEP_GO:  state_in = twcm_pkg::ST_STEP_DIV;
         twcm_pkg::ST_STEP_DIV: begin
            if (div_status.done) begin
               state_in = twcm_pkg::ST_MUL;
            end
         end
         twcm_pkg::ST_MUL: state_in = twcm_pkg::ST_SAT;
         twcm_pkg::ST_SAT: state_in = twcm_pkg::ST_IDLE;
         default:          state_in = twcm_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      div_start     = 1'b0;
      store_div_col = 1'b0;
      store_step    = 1'b0;
      load_prod     = 1'b0;
      load_pos      = 1'b0;
      unique case (state_ff)
         twcm_pkg::ST_IDLE:     div_start     = start_fire && door_c && !skipped_c;
         twcm_pkg::ST_COL_DIV:  store_div_col = div_status.done;
         twcm_pkg::ST_STEP_GO:  div_start     = 1'b1;
         twcm_pkg::ST_STEP_DIV: store_step    = div_status.done;
         twcm_pkg::ST_MUL:      load_prod     = 1'b1;
         twcm_pkg::ST_SAT:      load_pos      = 1'b1;
         default:               div_start     = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= twcm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Column setup registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tex_rows_ff <= 11'd1;
      end else if (start_fire) begin
         tex_rows_ff <= twcm_pkg::clamp_size(req_bus.texture_height);
      end
   end

   always_ff @(posedge clock) begin
      if (start_fire) begin
         column_id_ff   <= req_bus.column;
         span_top_ff    <= req_bus.wall_top;
         span_bottom_ff <= req_bus.wall_bottom;
         side_ff        <= req_bus.vertical_side;
         width_ff       <= width_c;
         span_ff        <= span_c;
         mirror_ff      <= mirror_c;
         skipped_ff     <= skipped_c;
         texel_x_ff     <= texel_x_c;
      end else if (store_div_col) begin
         texel_x_ff <= twcm_pkg::finish_texel_x(div_quotient, width_ff, mirror_ff);
      end
      if (store_step) begin
         step_ff <= div_quotient;
      end
   end

   // Start position: (max(top,0) - rows/2 + span/2) * step, then saturate.
   logic [10:0]                        first_row;
   logic signed [twcm_pkg::SUM_W-1:0]  row_offset;
   logic signed [twcm_pkg::STEP_W:0]   step_signed;
   logic [31:0]                        pos_start;

   assign first_row   = span_top_ff[11] ? 11'd0 : span_top_ff[10:0];
   assign row_offset  = $signed(twcm_pkg::SUM_W'(first_row))
                      - $signed(twcm_pkg::SUM_W'(twcm_pkg::HALF_ROWS))
                      + $signed(twcm_pkg::SUM_W'(span_ff[15:1]));
   assign step_signed = $signed({1'b0, step_ff});

   always_ff @(posedge clock) begin
      if (load_prod) begin
         prod_ff <= row_offset * step_signed;
      end
   end

   always_comb begin
      if (!prod_ff[twcm_pkg::PROD_W-1] && (prod_ff[twcm_pkg::PROD_W-2:31] != '0)) begin
         pos_start = 32'h7FFF_FFFF;
      end else if (prod_ff[twcm_pkg::PROD_W-1] && (prod_ff[twcm_pkg::PROD_W-2:31] != '1)) begin
         pos_start = 32'h8000_0000;
      end else begin
         pos_start = prod_ff[31:0];
      end
   end

   // Row evaluation
   logic signed [12:0] row_s;
   logic               below_bottom;
   logic               below_top;
   twcm_pkg::region_type region_c;
   logic [32:0]        pos_sum;
   logic [31:0]        pos_step;
   logic [14:0]        pos_row;
   logic [9:0]         texel_y_c;
   logic               last_row;

   assign row_s        = $signed({3'b000, row_ff});
   assign below_bottom = row_s >= $signed({span_bottom_ff[11], span_bottom_ff});
   assign below_top    = row_s >= $signed({span_top_ff[11], span_top_ff});
   assign pos_row      = pos_ff[30:16];
   assign last_row     = ({1'b0, row_ff} + 11'd1) >= 11'(twcm_pkg::SCREEN_ROWS);

   always_comb begin
      if (below_bottom) begin
         region_c = twcm_pkg::REGION_FLOOR;
      end else if (below_top) begin
         region_c = skipped_ff ? twcm_pkg::REGION_NONE : twcm_pkg::REGION_WALL;
      end else begin
         region_c = twcm_pkg::REGION_CEILING;
      end
   end

   always_comb begin
      if (pos_ff[31]) begin
         texel_y_c = 10'd0;
      end else if (pos_row >= 15'(tex_rows_ff)) begin
         texel_y_c = 10'(tex_rows_ff - 11'd1);
      end else begin
         texel_y_c = pos_row[9:0];
      end
   end

   // The step is never negative, so only the positive limit can be crossed.
   assign pos_sum  = {pos_ff[31], pos_ff} + {6'd0, step_ff};
   assign pos_step = (!pos_sum[32] && pos_sum[31]) ? 32'h7FFF_FFFF : pos_sum[31:0];

   always_comb begin
      pos_in  = pos_ff;
      row_in  = row_ff;
      open_in = open_ff;
      if (load_pos) begin
         pos_in  = pos_start;
         row_in  = '0;
         open_in = 1'b1;
      end else if (row_fire && open_ff) begin
         row_in = row_ff + 10'd1;
         if (region_c == twcm_pkg::REGION_WALL) begin
            pos_in = pos_step;
         end
         if (last_row) begin
            open_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         row_ff  <= '0;
         open_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         row_ff  <= row_in;
         open_ff <= open_in;
      end
   end

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_load;
   logic [10:0] out_column_ff;
   logic [9:0]  out_row_ff;
   twcm_pkg::region_type region_ff;
   logic [23:0] fill_rgb_ff;
   logic [9:0]  texel_x_out_ff;
   logic [9:0]  texel_y_ff;
   logic        shade_half_ff;
   logic        column_done_ff;

   assign rsp_load = row_fire && open_ff;

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         out_column_ff  <= column_id_ff;
         out_row_ff     <= row_ff;
         region_ff      <= region_c;
         column_done_ff <= last_row;
         unique case (region_c)
            twcm_pkg::REGION_FLOOR:   fill_rgb_ff <= floor_ff;
            twcm_pkg::REGION_CEILING: fill_rgb_ff <= ceiling_ff;
            default:                  fill_rgb_ff <= '0;
         endcase
         if (region_c == twcm_pkg::REGION_WALL) begin
            texel_x_out_ff <= texel_x_ff;
            texel_y_ff     <= texel_y_c;
            shade_half_ff  <= side_ff;
         end else begin
            texel_x_out_ff <= '0;
            texel_y_ff     <= '0;
            shade_half_ff  <= 1'b0;
         end
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.out_column  = out_column_ff;
   assign rsp_bus.out_row     = out_row_ff;
   assign rsp_bus.region      = region_ff;
   assign rsp_bus.fill_rgb    = fill_rgb_ff;
   assign rsp_bus.texel_x     = texel_x_out_ff;
   assign rsp_bus.texel_y     = texel_y_ff;
   assign rsp_bus.shade_half  = shade_half_ff;
   assign rsp_bus.column_done = column_done_ff;

   // Assertions
   a_start_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      start_fire |=> state_ff != twcm_pkg::ST_IDLE)
      else $error("start transfer did not launch the column setup");

   a_div_done_in_div_state: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == twcm_pkg::ST_COL_DIV ||
                           state_ff == twcm_pkg::ST_STEP_DIV))
      else $error("divider finished outside a divide state");

   a_divider_quiet_when_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == twcm_pkg::ST_IDLE |-> !div_status.busy)
      else $error("divider busy while the sequencer is idle");

   a_done_on_last_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && column_done_ff |->
         out_row_ff == 10'(twcm_pkg::SCREEN_ROWS - 1))
      else $error("column done flagged on a row other than the last");

   a_texel_y_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && region_ff == twcm_pkg::REGION_WALL |->
         {1'b0, texel_y_ff} < tex_rows_ff)
      else $error("texel row beyond texture height");

endmodule

`default_nettype wire

>>> sim/twcm_row_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// twcm_row_checker: row result predictor and scoreboard of the column mapper
// Snoops the request channel, the colour register writes and the response
// channel. Every accepted start item reloads a private copy of the column
// state, every accepted row item of an open column queues the row result it
// must produce, and every accepted response is compared with the oldest one.
// ---------------------------------------------------------------------------
module twcm_row_checker (
   input  logic        clock,
   input  logic        reset,
   twcm_req_if         req_mon,
   twcm_rsp_if         rsp_mon,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [23:0] csr_write_data,
   output int          fail_count,
   output int          pending_rows,
   output int          rows_checked,
   output int          columns_finished
);

   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;

   typedef struct packed {
      logic [10:0]          column;
      logic [9:0]           row;
      twcm_pkg::region_type region;
      logic [23:0]          fill;
      logic [9:0]           texel_x;
      logic [9:0]           texel_y;
      logic                 shade;
      logic                 done;
   } row_result_type;

   logic [23:0] ceiling_colour;
   logic [23:0] floor_colour;
   int          row_index;
   int          tex_pos;
   longint      tex_step_q;
   logic [9:0]  col_texel;
   logic        wall_hidden;
   int          top_row;
   int          bottom_row;
   logic        y_side;
   int          texture_rows;
   logic [10:0] column_latched;
   logic        column_live;
   row_result_type pending_row_results[$];

   function automatic int saturate_s32(input longint value);
      if (value > S32_MAX) begin
         return int'(S32_MAX);
      end else if (value < S32_MIN) begin
         return int'(S32_MIN);
      end
      return int'(value);
   endfunction

   function automatic int texture_extent(input logic [10:0] raw);
      if (raw == 11'd0) begin
         return 1;
      end else if (raw > twcm_pkg::TEX_SIZE_MAX) begin
         return int'(twcm_pkg::TEX_SIZE_MAX);
      end
      return int'(raw);
   endfunction

   task automatic load_ray_hit();
      longint hit;
      longint door;
      longint width;
      longint span;
      longint tx;
      int     first;
      hit = longint'(req_mon.hit_fraction);
      door = longint'(req_mon.door_open);
      width = texture_extent(req_mon.texture_width);
      span = (req_mon.wall_span == 16'd0) ? 1 : longint'(req_mon.wall_span);
      column_latched = req_mon.column;
      top_row = int'($signed(req_mon.wall_top));
      bottom_row = int'($signed(req_mon.wall_bottom));
      y_side = req_mon.vertical_side;
      texture_rows = texture_extent(req_mon.texture_height);
      // A hit inside the opened part of a door leaves the wall out.
      wall_hidden = (door > 0) && (hit < door);
      tx = 0;
      if (!wall_hidden) begin
         if (door > 0) begin
            tx = ((hit - door) * width) / (65536 - door);
         end else begin
            tx = (hit * width) >>> 16;
         end
         if (tx >= width) begin
            tx = width - 1;
         end
         if ((!y_side && req_mon.ray_x_positive) || (y_side && req_mon.ray_y_negative)) begin
            tx = width - tx - 1;
         end
      end
      col_texel = tx[9:0];
      tex_step_q = (longint'(texture_rows) << 16) / span;
      first = (top_row < 0) ? 0 : top_row;
      tex_pos = saturate_s32((longint'(first) - twcm_pkg::SCREEN_ROWS / 2 + span / 2)
                             * tex_step_q);
      row_index = 0;
      column_live = 1'b1;
   endtask

   task automatic map_next_row();
      row_result_type res;
      longint         ty;
      res = '0;
      res.column = column_latched;
      res.row = row_index[9:0];
      if (row_index >= bottom_row) begin
         res.region = twcm_pkg::REGION_FLOOR;
         res.fill = floor_colour;
      end else if (row_index >= top_row) begin
         if (wall_hidden) begin
            res.region = twcm_pkg::REGION_NONE;
         end else begin
            res.region = twcm_pkg::REGION_WALL;
            if (tex_pos < 0) begin
               ty = 0;
            end else begin
               ty = longint'(tex_pos) >>> 16;
               if (ty >= texture_rows) begin
                  ty = texture_rows - 1;
               end
            end
            tex_pos = saturate_s32(longint'(tex_pos) + tex_step_q);
            res.texel_x = col_texel;
            res.texel_y = ty[9:0];
            res.shade = y_side;
         end
      end else begin
         res.region = twcm_pkg::REGION_CEILING;
         res.fill = ceiling_colour;
      end
      if (row_index + 1 >= twcm_pkg::SCREEN_ROWS) begin
         res.done = 1'b1;
         column_live = 1'b0;
      end
      row_index++;
      pending_row_results.push_back(res);
   endtask

   task automatic compare_field(input string name, input logic [23:0] want,
                                input logic [23:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   task automatic check_row_result();
      row_result_type want;
      if (pending_row_results.size() == 0) begin
         $error("row result for column %0d row %0d with no row item outstanding",
                rsp_mon.out_column, rsp_mon.out_row);
         fail_count++;
      end else begin
         want = pending_row_results.pop_front();
         compare_field("out_column", want.column, rsp_mon.out_column);
         compare_field("out_row", want.row, rsp_mon.out_row);
         compare_field("region", want.region, rsp_mon.region);
         compare_field("fill_rgb", want.fill, rsp_mon.fill_rgb);
         compare_field("texel_x", want.texel_x, rsp_mon.texel_x);
         compare_field("texel_y", want.texel_y, rsp_mon.texel_y);
         compare_field("shade_half", want.shade, rsp_mon.shade_half);
         compare_field("column_done", want.done, rsp_mon.column_done);
         rows_checked++;
         if (want.done) begin
            columns_finished++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         ceiling_colour = '0;
         floor_colour = '0;
         row_index = 0;
         tex_pos = 0;
         tex_step_q = 0;
         col_texel = '0;
         wall_hidden = 1'b0;
         top_row = 0;
         bottom_row = 0;
         y_side = 1'b0;
         texture_rows = 1;
         column_latched = '0;
         column_live = 1'b0;
         pending_row_results.delete();
         fail_count = 0;
         rows_checked = 0;
         columns_finished = 0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == twcm_pkg::CSR_CEILING) begin
               ceiling_colour = csr_write_data;
            end else begin
               floor_colour = csr_write_data;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.action == twcm_pkg::ACTION_START) begin
               load_ray_hit();
            end else if (column_live) begin
               map_next_row();
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_row_result();
         end
      end
      pending_rows = pending_row_results.size();
   end

endmodule

>>> sim/textured_wall_column_mapper_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// textured_wall_column_mapper_tb: stimulus and verdict for the column mapper
// Drives directed start and row items, then random columns under four pacing
// phases with colour changes in between, and leaves all checking to the row
// checker that sits beside the mapper.
// ---------------------------------------------------------------------------
module textured_wall_column_mapper_tb;

   localparam int CLOCK_PERIOD_NS   = 10;
   localparam int RESET_CYCLES      = 9;
   localparam int TOTAL_ITEMS       = 1250;
   localparam int SETTLE_CYCLES     = 100;
   localparam int LONG_HOLD_CYCLES  = 300;
   localparam int TIMEOUT_CYCLES    = 300000;

   typedef struct packed {
      logic        action;
      logic [10:0] column;
      logic [11:0] wall_top;
      logic [11:0] wall_bottom;
      logic [15:0] wall_span;
      logic [15:0] hit_fraction;
      logic        vertical_side;
      logic        ray_x_positive;
      logic        ray_y_negative;
      logic [15:0] door_open;
      logic [10:0] texture_width;
      logic [10:0] texture_height;
   } ray_item_type;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic        csr_index;
   logic [23:0] csr_write_data;

   int fail_count;
   int pending_rows;
   int rows_checked;
   int columns_finished;
   int items_sent;
   int starts_sent;
   int sender_idle_pct;
   int receiver_stall_pct;
   bit long_hold_request;

   twcm_req_if req_bus ();
   twcm_rsp_if rsp_bus ();

   textured_wall_column_mapper u_top (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   twcm_row_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_rows     (pending_rows),
      .rows_checked     (rows_checked),
      .columns_finished (columns_finished)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD_NS / 2) clock = ~clock;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD_NS);
      $display("CHECKS FAILED");
      $finish;
   end

   // flags = {vertical_side, ray_x_positive, ray_y_negative}
   function automatic ray_item_type ray_start(input logic [10:0] column, input int top,
                                              input int bottom, input logic [15:0] span,
                                              input logic [15:0] hit, input logic [2:0] flags,
                                              input logic [15:0] door,
                                              input logic [10:0] width,
                                              input logic [10:0] height);
      ray_item_type it;
      it.action = twcm_pkg::ACTION_START;
      it.column = column;
      it.wall_top = 12'(top);
      it.wall_bottom = 12'(bottom);
      it.wall_span = span;
      it.hit_fraction = hit;
      {it.vertical_side, it.ray_x_positive, it.ray_y_negative} = flags;
      it.door_open = door;
      it.texture_width = width;
      it.texture_height = height;
      return it;
   endfunction

   // Row items ignore their payload, so it is left fully random.
   function automatic ray_item_type random_row();
      ray_item_type it;
      it.action = twcm_pkg::ACTION_ROW;
      it.column = 11'($urandom);
      it.wall_top = 12'($urandom);
      it.wall_bottom = 12'($urandom);
      it.wall_span = 16'($urandom);
      it.hit_fraction = 16'($urandom);
      it.vertical_side = 1'($urandom);
      it.ray_x_positive = 1'($urandom);
      it.ray_y_negative = 1'($urandom);
      it.door_open = 16'($urandom);
      it.texture_width = 11'($urandom);
      it.texture_height = 11'($urandom);
      return it;
   endfunction

   function automatic logic [10:0] pick_extent(input logic [10:0] raw);
      case ($urandom_range(0, 7))
         0: return raw;
         1: return 11'd1;
         2: return twcm_pkg::TEX_SIZE_MAX;
         default: return 11'($urandom_range(1, 1024));
      endcase
   endfunction

   function automatic ray_item_type random_ray(input bit full_column);
      ray_item_type it;
      int           top;
      it = random_row();
      it.action = twcm_pkg::ACTION_START;
      if (full_column) begin
         // Long walls with small spans push the texture position into saturation.
         top = ($urandom_range(0, 1) == 0) ? -int'($urandom_range(0, 2048))
                                          : int'($urandom_range(0, 100));
         it.wall_top = 12'(top);
         it.wall_bottom = 12'($urandom_range(300, 2047));
         it.wall_span = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 8))
                                                    : 16'($urandom);
      end else begin
         // Short columns only see the first rows, so keep the wall near the top.
         top = int'($urandom_range(0, 60)) - 20;
         if ($urandom_range(0, 3) != 0) begin
            it.wall_top = 12'(top);
         end
         if ($urandom_range(0, 3) != 0) begin
            it.wall_bottom = 12'(top + int'($urandom_range(0, 40)));
         end
         case ($urandom_range(0, 7))
            0: it.wall_span = 16'd0;
            1, 2: it.wall_span = 16'($urandom);
            default: it.wall_span = 16'($urandom_range(1, 600));
         endcase
      end
      if ($urandom_range(0, 1) == 0) begin
         it.door_open = 16'd0;
      end
      it.texture_width = pick_extent(it.texture_width);
      it.texture_height = pick_extent(it.texture_height);
      return it;
   endfunction

   task automatic present(input ray_item_type it);
      req_bus.action <= it.action;
      req_bus.column <= it.column;
      req_bus.wall_top <= it.wall_top;
      req_bus.wall_bottom <= it.wall_bottom;
      req_bus.wall_span <= it.wall_span;
      req_bus.hit_fraction <= it.hit_fraction;
      req_bus.vertical_side <= it.vertical_side;
      req_bus.ray_x_positive <= it.ray_x_positive;
      req_bus.ray_y_negative <= it.ray_y_negative;
      req_bus.door_open <= it.door_open;
      req_bus.texture_width <= it.texture_width;
      req_bus.texture_height <= it.texture_height;
   endtask

   // Returns at the clock edge on which the transfer took place.
   task automatic send_item(input ray_item_type it, input bit counted);
      if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_idle_pct);
      end
      present(it);
      req_bus.valid <= 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (counted) begin
         items_sent++;
         if (it.action == twcm_pkg::ACTION_START) begin
            starts_sent++;
         end
      end
   endtask

   task automatic send_rows(input int count, input bit counted);
      for (int i = 0; i < count; i++) begin
         send_item(random_row(), counted);
      end
   endtask

   // Start items produce no result, so give the last one time to finish too.
   task automatic drain();
      req_bus.valid <= 1'b0;
      wait (pending_rows == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_colours(input logic [23:0] ceiling, input logic [23:0] ground);
      csr_write_enable <= 1'b1;
      csr_index <= twcm_pkg::CSR_CEILING;
      csr_write_data <= ceiling;
      @(posedge clock);
      csr_index <= twcm_pkg::CSR_FLOOR;
      csr_write_data <= ground;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin : receiver
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            for (int i = 0; i < LONG_HOLD_CYCLES; i++) begin
               rsp_bus.ready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   initial begin : stimulus
      int phase;
      int goal;
      items_sent = 0;
      starts_sent = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      long_hold_request = 1'b0;
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index <= twcm_pkg::CSR_CEILING;
      csr_write_data <= '0;
      present('0);
      req_bus.valid <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_colours(24'hFFFFFF, 24'h000000);

      // A row with no column open is swallowed without a result.
      send_item(random_row(), 1'b0);
      // Largest hit fraction, mirrored x-side hit.
      send_item(ray_start(11'd0, -10, 5, 16'd15, 16'hFFFF, 3'b010, 16'd0, 11'd64, 11'd64), 1'b1);
      send_rows(3, 1'b1);
      // Abandons the open column; zero span, zero width, oversized height,
      // mirrored y-side hit and a start position that saturates low.
      send_item(ray_start(11'd2047, 2, 4, 16'd0, 16'd0, 3'b101, 16'd0, 11'd0, 11'd2047), 1'b1);
      send_rows(5, 1'b1);
      // Hit inside the open part of a door: the wall rows write nothing.
      send_item(ray_start(11'd5, 0, 2, 16'd100, 16'd100, 3'b000, 16'd200, 11'd1024, 11'd1024),
                1'b1);
      send_rows(3, 1'b1);
      // Widest door with the hit on its edge, lowest wall top, largest span.
      send_item(ray_start(11'd6, -2048, 2047, 16'hFFFF, 16'hFFFF, 3'b110, 16'hFFFF, 11'd1024,
                          11'd1), 1'b1);
      send_rows(2, 1'b1);
      // Highest wall top and bottom, oversized width behind a quarter open door.
      send_item(ray_start(11'd7, 2047, 2047, 16'd2, 16'h8000, 3'b001, 16'h4000, 11'd2047,
                          11'd1024), 1'b1);
      send_rows(1, 1'b1);
      // Lowest wall bottom: floor from the first row on.
      send_item(ray_start(11'd8, 0, -2048, 16'd1, 16'h4000, 3'b100, 16'h8000, 11'd3, 11'd1000),
                1'b1);
      send_rows(1, 1'b1);

      for (phase = 0; phase < 4; phase++) begin
         drain();
         case (phase)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
               set_colours(24'($urandom), 24'($urandom));
            end
            1: begin
               sender_idle_pct = 54;
               receiver_stall_pct = 0;
               set_colours(24'h000000, 24'hFFFFFF);
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 54;
               set_colours(24'($urandom), 24'($urandom));
            end
            default: begin
               sender_idle_pct = 36;
               receiver_stall_pct = 36;
               set_colours(24'h7F7F7F, 24'($urandom));
            end
         endcase
         goal = TOTAL_ITEMS * (phase + 1) / 4;
         if (phase == 0 || phase == 2) begin
            // One whole column; the rows offered after it closes are dropped.
            send_item(random_ray(1'b1), 1'b1);
            if (phase == 0) begin
               long_hold_request = 1'b1;
            end
            send_rows(twcm_pkg::SCREEN_ROWS, 1'b1);
            send_rows($urandom_range(1, 4), 1'b0);
         end
         while (items_sent < goal) begin
            send_item(random_ray(1'b0), 1'b1);
            send_rows($urandom_range(0, 40), 1'b1);
         end
      end
      drain();

      $display("Covered %0d accepted items with %0d column starts, %0d row results checked,",
               items_sent, starts_sent, rows_checked);
      $display("%0d full columns, four pacing phases and one long receiver hold.",
               columns_finished);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/twcm_pkg.sv
hw/rtl/twcm_if.sv
hw/rtl/twcm_divider.sv
hw/rtl/textured_wall_column_mapper.sv
sim/twcm_row_checker.sv
sim/textured_wall_column_mapper_tb.sv
